// ===== design/lae_pkg.sv =====
package lae_pkg;

	localparam int LEVEL_BITS_DEF = 16;
	localparam int TIME_BITS_DEF  = 24;
	localparam int CMD_W          = 2;
	localparam int STEP_W         = 16;
	localparam int PHASE_W        = 3;
	localparam int CFG_IDX_W      = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 2'd0,
		CMD_KEY_DOWN = 2'd1,
		CMD_KEY_UP   = 2'd2
	} cmd_code_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK  = 2'd0,
		REG_DECAY   = 2'd1,
		REG_SUSTAIN = 2'd2,
		REG_RELEASE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic take;
		logic exec;
		logic decide;
		logic mul;
		logic div;
		logic wb;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic need_math;
	} dp_status_t;

endpackage

// ===== design/lae_datapath.sv =====
module lae_datapath #(
	parameter int LEVEL_BITS = lae_pkg::LEVEL_BITS_DEF,
	parameter int TIME_BITS  = lae_pkg::TIME_BITS_DEF,
	parameter int CFG_W      = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lae_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic [lae_pkg::CMD_W-1:0]    command,
	input  logic [lae_pkg::STEP_W-1:0]   time_step,
	input  lae_pkg::ctl_cmd_t            cmd,
	output lae_pkg::dp_status_t          status,
	output logic [LEVEL_BITS-1:0]        level,
	output logic [lae_pkg::PHASE_W-1:0]  phase
);

	localparam int TMR_W = TIME_BITS + 1;
	localparam int SUM_W = ((TMR_W > lae_pkg::STEP_W) ? TMR_W : lae_pkg::STEP_W) + 1;
	localparam int PW    = TIME_BITS + LEVEL_BITS;
	localparam logic [LEVEL_BITS-1:0] FULL    = '1;
	localparam logic [TMR_W-1:0]      TMR_MAX = '1;

	logic [TIME_BITS-1:0]  attack_q, decay_q, release_q;
	logic [LEVEL_BITS-1:0] sustain_q;

	logic [lae_pkg::CMD_W-1:0]  cmd_q;
	logic [lae_pkg::STEP_W-1:0] step_q;

	lae_pkg::phase_t       phase_q;
	logic [LEVEL_BITS-1:0] level_q, peak_q;
	logic [TMR_W-1:0]      timer_q;

	logic [LEVEL_BITS-1:0] mx_q;
	logic [TIME_BITS-1:0]  dv_q;
	logic [PW-1:0]         p_q;

	logic [LEVEL_BITS-1:0]       lvl_out_q;
	logic [lae_pkg::PHASE_W-1:0] ph_out_q;

	logic [SUM_W-1:0]      sum;
	logic [TMR_W-1:0]      timer_add;
	logic                  atk_end, dec_end, rel_off, rel_zero;
	logic [TIME_BITS:0]    trial, diff;
	logic                  ge;
	logic [TIME_BITS-1:0]  new_rem;
	logic [PW-1:0]         addend;
	logic [LEVEL_BITS-1:0] quo;

	always_comb begin
		sum       = SUM_W'(timer_q) + SUM_W'(step_q);
		timer_add = (sum > SUM_W'(TMR_MAX)) ? TMR_MAX : sum[TMR_W-1:0];
		atk_end   = (attack_q == '0) || (timer_q > {1'b0, attack_q});
		dec_end   = (decay_q == '0) || (timer_q > {1'b0, decay_q});
		rel_off   = (release_q == '0) || (level_q == '0);
		rel_zero  = timer_q >= {1'b0, release_q};
		trial     = {p_q[PW-1:LEVEL_BITS], p_q[LEVEL_BITS-1]};
		diff      = trial - {1'b0, dv_q};
		ge        = trial >= {1'b0, dv_q};
		new_rem   = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
		addend    = mx_q[LEVEL_BITS-1] ? {{LEVEL_BITS{1'b0}}, timer_q[TIME_BITS-1:0]} : '0;
		quo       = p_q[LEVEL_BITS-1:0];
	end

	always_comb begin
		status.is_tick   = (cmd_q == lae_pkg::CMD_TICK);
		status.need_math = ((phase_q == lae_pkg::PH_ATTACK) && !atk_end) ||
			((phase_q == lae_pkg::PH_DECAY) && !dec_end) ||
			((phase_q == lae_pkg::PH_RELEASE) && !rel_off && !rel_zero);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			decay_q   <= '0;
			sustain_q <= FULL;
			release_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lae_pkg::REG_ATTACK:  attack_q  <= cfg_data[TIME_BITS-1:0];
				lae_pkg::REG_DECAY:   decay_q   <= cfg_data[TIME_BITS-1:0];
				lae_pkg::REG_SUSTAIN: sustain_q <= cfg_data[LEVEL_BITS-1:0];
				lae_pkg::REG_RELEASE: release_q <= cfg_data[TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lae_pkg::PH_IDLE;
			level_q <= '0;
			peak_q  <= '0;
			timer_q <= '0;
		end else begin
			if (cmd.exec) begin
				case (cmd_q)
					lae_pkg::CMD_TICK: timer_q <= timer_add;
					lae_pkg::CMD_KEY_DOWN: begin
						level_q <= '0;
						timer_q <= '0;
						phase_q <= lae_pkg::PH_ATTACK;
					end
					lae_pkg::CMD_KEY_UP: begin
						if (phase_q inside {lae_pkg::PH_ATTACK, lae_pkg::PH_DECAY,
							lae_pkg::PH_SUSTAIN}) begin
							phase_q <= lae_pkg::PH_RELEASE;
							peak_q  <= level_q;
							timer_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.decide) begin
				case (phase_q)
					lae_pkg::PH_ATTACK: begin
						if (atk_end) begin
							phase_q <= lae_pkg::PH_DECAY;
							timer_q <= '0;
							level_q <= FULL;
						end
					end
					lae_pkg::PH_DECAY: begin
						if (dec_end) begin
							phase_q <= lae_pkg::PH_SUSTAIN;
							timer_q <= '0;
							level_q <= sustain_q;
						end
					end
					lae_pkg::PH_SUSTAIN: level_q <= sustain_q;
					lae_pkg::PH_RELEASE: begin
						if (rel_off) begin
							phase_q <= lae_pkg::PH_IDLE;
							level_q <= '0;
						end else if (rel_zero) begin
							level_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.wb) begin
				case (phase_q)
					lae_pkg::PH_ATTACK:  level_q <= quo;
					lae_pkg::PH_DECAY:   level_q <= FULL - quo;
					lae_pkg::PH_RELEASE: level_q <= peak_q - quo;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q  <= command;
			step_q <= time_step;
		end
		if (cmd.decide) begin
			p_q <= '0;
			case (phase_q)
				lae_pkg::PH_ATTACK: begin
					mx_q <= FULL;
					dv_q <= attack_q;
				end
				lae_pkg::PH_DECAY: begin
					mx_q <= FULL - sustain_q;
					dv_q <= decay_q;
				end
				default: begin
					mx_q <= peak_q;
					dv_q <= release_q;
				end
			endcase
		end
		if (cmd.mul) begin
			p_q  <= (p_q << 1) + addend;
			mx_q <= mx_q << 1;
		end
		if (cmd.div) begin
			p_q <= {new_rem, p_q[LEVEL_BITS-2:0], ge};
		end
		if (cmd.out_load) begin
			lvl_out_q <= level_q;
			ph_out_q  <= phase_q;
		end
	end

	assign level = lvl_out_q;
	assign phase = ph_out_q;

endmodule

// ===== design/lae_controller.sv =====
module lae_controller #(
	parameter int LEVEL_BITS = lae_pkg::LEVEL_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  lae_pkg::dp_status_t status,
	output lae_pkg::ctl_cmd_t   cmd
);

	localparam int CNT_W = $clog2(LEVEL_BITS);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_MUL    = 7'b0001000,
		S_DIV    = 7'b0010000,
		S_WB     = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic             cnt_last;

	assign cnt_last  = (cnt_q == CNT_W'(LEVEL_BITS - 1));
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.is_tick ? S_DECIDE : S_DONE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				cnt_d      = '0;
				state_d    = status.need_math ? S_MUL : S_DONE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = cnt_last ? '0 : cnt_q + 1'b1;
				if (cnt_last) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				cnt_d   = cnt_last ? '0 : cnt_q + 1'b1;
				if (cnt_last) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/linear_adsr_envelope.sv =====
// Channel  Direction  Handshake             Payload
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in         in_valid/in_stall     command, time_step
// out      out        out_valid/out_stall   level, phase
//
// A key event is taken, executed and loaded as a result; a tick also passes a decide step
// and, when a ramp is computed, a multiply pass, a divide pass and a write-back before loading.
// The ramp value uses one shift-add multiplier and one restoring divider, each one bit a cycle.
// A new transaction is accepted once the previous result sits in the output register.
// Reset at once clears phase, level, peak, timer and ramp times and sets sustain to full scale.
// A stalled output holds its result, and the next result waits until it is taken.
module linear_adsr_envelope #(
	parameter int LEVEL_BITS = lae_pkg::LEVEL_BITS_DEF,
	parameter int TIME_BITS  = lae_pkg::TIME_BITS_DEF,
	parameter int CFG_W      = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lae_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lae_pkg::CMD_W-1:0]     command,
	input  logic [lae_pkg::STEP_W-1:0]    time_step,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [LEVEL_BITS-1:0]         level,
	output logic [lae_pkg::PHASE_W-1:0]   phase
);

	lae_pkg::ctl_cmd_t   cmd;
	lae_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	lae_controller #(
		.LEVEL_BITS(LEVEL_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lae_datapath #(
		.LEVEL_BITS(LEVEL_BITS),
		.TIME_BITS (TIME_BITS),
		.CFG_W     (CFG_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.command  (command),
		.time_step(time_step),
		.cmd      (cmd),
		.status   (status),
		.level    (level),
		.phase    (phase)
	);

endmodule

// ===== tb/linear_adsr_envelope_test.sv =====
`timescale 1ns / 100ps

module linear_adsr_envelope_test;

	localparam int LEVEL_W = lae_pkg::LEVEL_BITS_DEF;
	localparam int TIME_W = lae_pkg::TIME_BITS_DEF;
	localparam int DATA_W = (TIME_W > LEVEL_W) ? TIME_W : LEVEL_W;
	localparam int CMD_W = lae_pkg::CMD_W;
	localparam int STEP_W = lae_pkg::STEP_W;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [LEVEL_W-1:0] FULL_SCALE = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam longint unsigned TIMER_SAT = (64'd1 << (TIME_W + 1)) - 1;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_SETTINGS = 8;
	localparam int ITEMS_PER_SETTING = 200;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		lae_pkg::phase_t phase;
	} envelope_out_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [lae_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [CMD_W-1:0] command;
	logic [STEP_W-1:0] time_step;
	logic out_valid;
	logic out_stall;
	logic [LEVEL_W-1:0] level;
	logic [lae_pkg::PHASE_W-1:0] phase;

	logic [TIME_W-1:0] attack_cfg;
	logic [TIME_W-1:0] decay_cfg;
	logic [TIME_W-1:0] release_cfg;
	logic [LEVEL_W-1:0] sustain_cfg;
	lae_pkg::phase_t env_phase;
	logic [LEVEL_W-1:0] env_level;
	logic [LEVEL_W-1:0] env_peak;
	longint unsigned env_timer;

	envelope_out_t expected_envelope[$];
	int error_count;
	int items_sent;
	int results_checked;
	int settings_count;
	int idle_cycles;
	int stall_hold;
	bit steady_flow;

	linear_adsr_envelope DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.time_step(time_step),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level(level),
		.phase(phase)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_length();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [STEP_W-1:0] pick_step(longint unsigned span);
		int r;
		longint unsigned lim;
		r = $urandom_range(0, 99);
		lim = span / 3 + 1;
		if (lim > 65535)
			lim = 65535;
		if (r < 5)
			return '0;
		if (r < 9)
			return '1;
		return STEP_W'($urandom_range(1, int'(lim)));
	endfunction

	function automatic logic [TIME_W-1:0] pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 50)
			return TIME_W'($urandom_range(1, 64));
		if (r < 80)
			return TIME_W'($urandom_range(65, 4096));
		if (r < 95)
			return TIME_W'($urandom_range(4097, 1 << 20));
		return TIME_W'($urandom);
	endfunction

	function automatic logic [DATA_W-1:0] pick_sustain();
		int r;
		logic [DATA_W-1:0] data;
		data = DATA_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 10)
			data[LEVEL_W-1:0] = '0;
		else if (r < 20)
			data[LEVEL_W-1:0] = '1;
		return data;
	endfunction

	task automatic report_mismatch(string what);
		if (error_count < 50)
			$display("%0t mismatch: %s", $time, what);
		error_count++;
	endtask

	task automatic envelope_step(logic [CMD_W-1:0] cmd, logic [STEP_W-1:0] step);
		longint unsigned full;
		longint unsigned t;
		longint unsigned att;
		longint unsigned dec;
		longint unsigned sus;
		longint unsigned rel;
		longint unsigned pk;
		envelope_out_t res;
		full = 64'(FULL_SCALE);
		att = 64'(attack_cfg);
		dec = 64'(decay_cfg);
		sus = 64'(sustain_cfg);
		rel = 64'(release_cfg);
		pk = 64'(env_peak);
		case (cmd)
		lae_pkg::CMD_TICK: begin
			env_timer = env_timer + 64'(step);
			if (env_timer > TIMER_SAT)
				env_timer = TIMER_SAT;
			t = env_timer;
			case (env_phase)
			lae_pkg::PH_ATTACK: begin
				if (att == 0 || t > att) begin
					env_phase = lae_pkg::PH_DECAY;
					env_timer = 0;
					env_level = FULL_SCALE;
				end else begin
					env_level = LEVEL_W'((t * full) / att);
				end
			end
			lae_pkg::PH_DECAY: begin
				if (dec == 0 || t > dec) begin
					env_phase = lae_pkg::PH_SUSTAIN;
					env_timer = 0;
					env_level = sustain_cfg;
				end else begin
					env_level = LEVEL_W'(full - (t * (full - sus)) / dec);
				end
			end
			lae_pkg::PH_SUSTAIN: env_level = sustain_cfg;
			lae_pkg::PH_RELEASE: begin
				if (rel == 0 || env_level == 0) begin
					env_phase = lae_pkg::PH_IDLE;
					env_level = '0;
				end else if (t >= rel) begin
					env_level = '0;
				end else begin
					env_level = LEVEL_W'(pk - (t * pk) / rel);
				end
			end
			default: ;
			endcase
		end
		lae_pkg::CMD_KEY_DOWN: begin
			env_level = '0;
			env_timer = 0;
			env_phase = lae_pkg::PH_ATTACK;
		end
		lae_pkg::CMD_KEY_UP: begin
			if (env_phase inside {lae_pkg::PH_ATTACK, lae_pkg::PH_DECAY,
					lae_pkg::PH_SUSTAIN}) begin
				env_phase = lae_pkg::PH_RELEASE;
				env_peak = env_level;
				env_timer = 0;
			end
		end
		default: ;
		endcase
		res.level = env_level;
		res.phase = env_phase;
		expected_envelope.push_back(res);
	endtask

	task automatic send_command(logic [CMD_W-1:0] cmd, logic [STEP_W-1:0] step);
		int gap;
		command <= cmd;
		time_step <= step;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		envelope_step(cmd, step);
		items_sent++;
		gap = gap_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results(int settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_envelope.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_register(lae_pkg::cfg_reg_t idx, logic [DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		lae_pkg::REG_ATTACK: attack_cfg = data[TIME_W-1:0];
		lae_pkg::REG_DECAY: decay_cfg = data[TIME_W-1:0];
		lae_pkg::REG_SUSTAIN: sustain_cfg = data[LEVEL_W-1:0];
		lae_pkg::REG_RELEASE: release_cfg = data[TIME_W-1:0];
		default: ;
		endcase
	endtask

	task automatic apply_settings(logic [DATA_W-1:0] att, logic [DATA_W-1:0] dec,
			logic [DATA_W-1:0] sus, logic [DATA_W-1:0] rel);
		wait_for_results(4);
		write_register(lae_pkg::REG_ATTACK, att);
		write_register(lae_pkg::REG_DECAY, dec);
		write_register(lae_pkg::REG_SUSTAIN, sus);
		write_register(lae_pkg::REG_RELEASE, rel);
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	task automatic play_note();
		longint unsigned ramp_span;
		ramp_span = 64'(attack_cfg) + 64'(decay_cfg);
		send_command(lae_pkg::CMD_KEY_DOWN, STEP_W'($urandom));
		repeat ($urandom_range(1, 10))
			send_command(lae_pkg::CMD_TICK, pick_step(ramp_span));
		if ($urandom_range(0, 7) != 0)
			send_command(lae_pkg::CMD_KEY_UP, STEP_W'($urandom));
		repeat ($urandom_range(1, 8))
			send_command(lae_pkg::CMD_TICK, pick_step(64'(release_cfg)));
	endtask

	task automatic test_reset_defaults();
		settings_count++;
		send_command(lae_pkg::CMD_TICK, 16'd100);
		send_command(lae_pkg::CMD_KEY_UP, '0);
		send_command(lae_pkg::CMD_KEY_DOWN, '0);
		send_command(lae_pkg::CMD_TICK, '0);
		send_command(lae_pkg::CMD_TICK, '0);
		send_command(CMD_UNUSED, '1);
		send_command(lae_pkg::CMD_KEY_UP, '0);
		send_command(lae_pkg::CMD_TICK, 16'd1);
	endtask

	task automatic test_ramp_extremes();
		apply_settings(DATA_W'(1), TIME_MAX, '0, DATA_W'(1));
		send_command(lae_pkg::CMD_KEY_DOWN, '0);
		send_command(lae_pkg::CMD_TICK, '0);
		send_command(lae_pkg::CMD_TICK, 16'd1);
		send_command(lae_pkg::CMD_TICK, 16'd1);
		send_command(lae_pkg::CMD_TICK, '1);
		send_command(lae_pkg::CMD_KEY_UP, '0);
		send_command(lae_pkg::CMD_TICK, '0);
		send_command(lae_pkg::CMD_TICK, 16'd1);
		send_command(lae_pkg::CMD_TICK, '0);
		send_command(lae_pkg::CMD_KEY_DOWN, '1);
		send_command(lae_pkg::CMD_KEY_UP, '1);
		send_command(lae_pkg::CMD_TICK, 16'd7);
	endtask

	task automatic test_saturated_durations();
		apply_settings(TIME_MAX, '0, 24'h5AFFFF, TIME_MAX);
		send_command(lae_pkg::CMD_KEY_DOWN, '0);
		send_command(lae_pkg::CMD_TICK, '1);
		send_command(lae_pkg::CMD_KEY_UP, '0);
		send_command(lae_pkg::CMD_TICK, '1);
		send_command(lae_pkg::CMD_KEY_UP, '0);
	endtask

	task automatic test_random_envelopes();
		int budget;
		for (int s = 0; s < RANDOM_SETTINGS; s++) begin
			steady_flow = (s % 4 == 3);
			apply_settings(pick_duration(), pick_duration(), pick_sustain(), pick_duration());
			budget = items_sent + ITEMS_PER_SETTING;
			while (items_sent < budget) begin
				if ($urandom_range(0, 9) == 0)
					send_command(CMD_W'($urandom_range(0, 3)), STEP_W'($urandom));
				else
					play_note();
				if ($urandom_range(0, 29) == 0)
					wait_for_results(1);
			end
		end
		steady_flow = 1'b0;
	endtask

	always @(posedge clk) begin
		if (!arst_n || steady_flow) begin
			out_stall <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_hold <= gap_length();
		end
	end

	always @(posedge clk) begin
		envelope_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_envelope.size() == 0) begin
				report_mismatch($sformatf("result level %0d phase %0d with nothing expected",
					level, phase));
			end else begin
				want = expected_envelope.pop_front();
				results_checked++;
				if (level !== want.level)
					report_mismatch($sformatf("level %0d, expected %0d", level, want.level));
				if (phase !== want.phase)
					report_mismatch($sformatf("phase %0d, expected %s", phase,
						want.phase.name()));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timed out with %0d results outstanding.", expected_envelope.size());
			$display("linear_adsr_envelope_test: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= lae_pkg::REG_ATTACK;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= lae_pkg::CMD_TICK;
		time_step <= '0;
		attack_cfg = '0;
		decay_cfg = '0;
		sustain_cfg = FULL_SCALE;
		release_cfg = '0;
		env_phase = lae_pkg::PH_IDLE;
		env_level = '0;
		env_peak = '0;
		env_timer = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_ramp_extremes();
		test_saturated_durations();
		test_random_envelopes();
		wait_for_results(40);
		$display("Sent %0d envelope commands under %0d register settings; %0d results compared.",
			items_sent, settings_count, results_checked);
		$display("Covered key events in every phase, skipped and full ramps, unused codes, stalls.");
		if (error_count == 0)
			$display("linear_adsr_envelope_test: clean");
		else
			$display("linear_adsr_envelope_test: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/lae_pkg.sv
design/lae_datapath.sv
design/lae_controller.sv
design/linear_adsr_envelope.sv
tb/linear_adsr_envelope_test.sv
